// File: hdl/qfom_pkg.sv
// Shared types and constants for the quadratic-form overlap magnitude unit.
// No dependencies.
package qfom_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int K_W        = 4;                             // qubit_count register width
  localparam int QF_W       = MAX_QUBITS * (MAX_QUBITS + 1) / 2; // 55 form bits
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 28;
  localparam int ABS_W      = 26;                            // |acc| <= 2^25
  localparam int SQ_W       = 2 * ABS_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int MAG_W      = 21;
  localparam int RAD_W      = 2 * MAG_W;                     // radicand bits under the cap
  localparam int REM_W      = MAG_W + 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = QF_W;

  localparam logic [CFG_IDX_W-1:0] REG_QUBIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD_FORM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_MASK = 2'd2;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef struct packed {
    logic [K_W-1:0]        qubit_count;
    logic [QF_W-1:0]       quad_form;
    logic [MAX_QUBITS-1:0] linear_mask;
  } qfom_cfg_t;

  // Finished sum of one block, handed from front to back.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc_re;
    logic signed [ACC_W-1:0] acc_im;
    logic [K_W-1:0]          k;
  } qfom_entry_t;

endpackage

// File: hdl/qfom_front.sv
// Front end: takes samples, applies the quadratic-form phase and accumulates.
// Pushes the finished sum of each block into the queue. Uses qfom_pkg.
module qfom_front (
  input  logic                              clk,
  input  logic                              rst,
  input  qfom_pkg::qfom_cfg_t               cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [qfom_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [qfom_pkg::SAMPLE_W-1:0] sample_im,
  input  logic                              q_full,
  output logic                              q_push,
  output qfom_pkg::qfom_entry_t             q_entry
);
  import qfom_pkg::*;

  logic [K_W-1:0]                          k_eff;
  logic [MAX_QUBITS-1:0]                   last_idx;
  logic [MAX_QUBITS-1:0]                   x;
  logic [MAX_QUBITS-1:0]                   sample_index;
  logic signed [ACC_W-1:0]                 acc_re;
  logic signed [ACC_W-1:0]                 acc_im;
  logic [MAX_QUBITS-1:0][MAX_QUBITS-1:0]   qsel;
  logic                                    quad;
  logic                                    lin;
  logic signed [SAMPLE_W:0]                re_x;
  logic signed [SAMPLE_W:0]                im_x;
  logic signed [SAMPLE_W:0]                p_re;
  logic signed [SAMPLE_W:0]                p_im;
  logic signed [ACC_W-1:0]                 sum_re;
  logic signed [ACC_W-1:0]                 sum_im;
  logic                                    accept;
  logic                                    is_last;

  always_comb begin
    if (cfg.qubit_count == '0) begin
      k_eff = K_W'(1);
    end else if (cfg.qubit_count > K_W'(MAX_QUBITS)) begin
      k_eff = K_W'(MAX_QUBITS);
    end else begin
      k_eff = cfg.qubit_count;
    end
  end

  assign last_idx = ~({MAX_QUBITS{1'b1}} << k_eff);
  assign x        = sample_index & last_idx;
  assign is_last  = sample_index >= last_idx;

  // Packed position of pair (i,j) moves with k; pick the form bit per pair.
  for (genvar i = 0; i < MAX_QUBITS; i++) begin : g_row
    for (genvar j = 0; j < MAX_QUBITS; j++) begin : g_col
      if (j >= i) begin : g_pair
        logic [MAX_QUBITS:0] cand;
        assign cand[0] = 1'b0;
        for (genvar kk = 1; kk <= MAX_QUBITS; kk++) begin : g_k
          localparam int POS = i * kk - (i * (i - 1)) / 2 + (j - i);
          if (j < kk && POS < QF_W) begin : g_on
            assign cand[kk] = cfg.quad_form[POS];
          end else begin : g_off
            assign cand[kk] = 1'b0;
          end
        end
        assign qsel[i][j] = cand[k_eff];
      end else begin : g_lower
        assign qsel[i][j] = 1'b0;
      end
    end
  end

  always_comb begin
    quad = 1'b0;
    for (int i = 0; i < MAX_QUBITS; i++) begin
      for (int j = 0; j < MAX_QUBITS; j++) begin
        quad = quad ^ (x[i] & x[j] & qsel[i][j]);
      end
    end
  end

  assign lin = ^(x & cfg.linear_mask);

  always_comb begin
    re_x = (SAMPLE_W+1)'(sample_re);
    im_x = (SAMPLE_W+1)'(sample_im);
    if (lin) begin
      p_re = -im_x;
      p_im = re_x;
    end else begin
      p_re = re_x;
      p_im = im_x;
    end
    if (quad) begin
      p_re = -p_re;
      p_im = -p_im;
    end
  end

  assign sum_re = acc_re + ACC_W'(p_re);
  assign sum_im = acc_im + ACC_W'(p_im);

  assign in_stall       = q_full;
  assign accept         = in_valid & ~q_full;
  assign q_push         = accept & is_last;
  assign q_entry.acc_re = sum_re;
  assign q_entry.acc_im = sum_im;
  assign q_entry.k      = k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re       <= '0;
      acc_im       <= '0;
      sample_index <= '0;
    end else if (accept) begin
      if (is_last) begin
        acc_re       <= '0;
        acc_im       <= '0;
        sample_index <= '0;
      end else begin
        acc_re       <= sum_re;
        acc_im       <= sum_im;
        sample_index <= sample_index + MAX_QUBITS'(1);
      end
    end
  end

endmodule

// File: hdl/qfom_queue.sv
// Short queue of finished block sums between front and back.
// Uses qfom_pkg for the entry type.
module qfom_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  qfom_pkg::qfom_entry_t wr_entry,
  input  logic                  pop,
  output qfom_pkg::qfom_entry_t rd_entry,
  output logic                  full,
  output logic                  empty
);
  import qfom_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qfom_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hdl/qfom_back.sv
// Back end: squares the block sum, scales by 2^-k and takes the integer
// square root one bit per cycle; drives the output register. Uses qfom_pkg.
module qfom_back (
  input  logic                        clk,
  input  logic                        rst,
  input  qfom_pkg::qfom_entry_t       q_entry,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [qfom_pkg::MAG_W-1:0]  overlap_mag
);
  import qfom_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_SUM    = 6'b000100,
    ST_SCALE  = 6'b001000,
    ST_ROOT   = 6'b010000,
    ST_DONE   = 6'b100000
  } back_state_t;

  localparam int CNT_W = $clog2(MAG_W);

  back_state_t        state;
  logic [ABS_W-1:0]   abs_re;
  logic [ABS_W-1:0]   abs_im;
  logic [K_W-1:0]     k;
  logic [SQ_W-1:0]    sq_re;
  logic [SQ_W-1:0]    sq_im;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   scaled;
  logic               sat;
  logic [RAD_W-1:0]   rad;
  logic [REM_W-1:0]   rem;
  logic [MAG_W-1:0]   root;
  logic [CNT_W-1:0]   cnt;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic               take;
  logic [REM_W-1:0]   rem_next;
  logic [MAG_W-1:0]   root_next;
  logic [ACC_W-1:0]   mag_re;
  logic [ACC_W-1:0]   mag_im;
  logic               load_out;

  assign mag_re = q_entry.acc_re[ACC_W-1] ? ACC_W'(-q_entry.acc_re) : ACC_W'(q_entry.acc_re);
  assign mag_im = q_entry.acc_im[ACC_W-1] ? ACC_W'(-q_entry.acc_im) : ACC_W'(q_entry.acc_im);

  assign scaled = sum >> k;

  // Restoring square root, two radicand bits per step.
  always_comb begin
    rem_sh = {rem, rad[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({root, 2'b01});
    take   = rem_sh >= trial;
    if (take) begin
      rem_next  = REM_W'(rem_sh - trial);
      root_next = {root[MAG_W-2:0], 1'b1};
    end else begin
      rem_next  = REM_W'(rem_sh);
      root_next = {root[MAG_W-2:0], 1'b0};
    end
  end

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE:   if (!q_empty) state <= ST_SQUARE;
        ST_SQUARE: state <= ST_SUM;
        ST_SUM:    state <= ST_SCALE;
        ST_SCALE:  state <= ST_ROOT;
        ST_ROOT:   if (cnt == CNT_W'(MAG_W - 1)) state <= ST_DONE;
        ST_DONE:   if (load_out) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      abs_re <= mag_re[ABS_W-1:0];
      abs_im <= mag_im[ABS_W-1:0];
      k      <= q_entry.k;
    end
    if (state == ST_SQUARE) begin
      sq_re <= abs_re * abs_re;
      sq_im <= abs_im * abs_im;
    end
    if (state == ST_SUM) begin
      sum <= SUM_W'(sq_re) + SUM_W'(sq_im);
    end
    if (state == ST_SCALE) begin
      sat  <= |scaled[SUM_W-1:RAD_W];
      rad  <= scaled[RAD_W-1:0];
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end
    if (state == ST_ROOT) begin
      rem  <= rem_next;
      root <= root_next;
      rad  <= {rad[RAD_W-3:0], 2'b00};
      cnt  <= cnt + CNT_W'(1);
    end
    if (load_out) begin
      overlap_mag <= sat ? MAG_MAX : root;
    end
  end

endmodule

// File: hdl/quadratic_form_overlap_magnitude_unit.sv
// Quadratic-form overlap magnitude unit: top level with configuration registers.
// Instantiates qfom_front, qfom_queue and qfom_back; uses qfom_pkg.
//
// Streams 2^k complex Q1.15 samples per block (k = qubit_count, 0 read as 1,
// above 10 read as 10), phases each by (-1)^(xQx) * i^(c.x) with x the arrival
// order inside the block, sums them exactly and returns one overlap_mag per
// block: floor(|sum| * 2^(-k/2)) in Q.15, saturated at 2^21-1. The front takes
// one sample per cycle while the queue is not full; the phase is an AND-XOR
// network and the sum a single add. Each finished block sum goes through a
// queue of QUEUE_DEPTH entries to the back end, which for each result pops,
// squares, adds, scales by 2^-k, runs 21 square-root steps and loads the
// output register. The back end's root loop sets the sustained rate for short
// blocks, and it takes no new block sum until its last result is loaded.
// A result waits in the output register while the back end moves on to the
// next block sum. Config writes take effect on the next sample and are meant
// for idle periods; a write to an index past linear_mask is ignored.
module quadratic_form_overlap_magnitude_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write,
  input  logic [qfom_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qfom_pkg::CFG_DATA_W-1:0]       cfg_data,
  // sample transactions
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [qfom_pkg::SAMPLE_W-1:0]  sample_re,
  input  logic signed [qfom_pkg::SAMPLE_W-1:0]  sample_im,
  // result transactions
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [qfom_pkg::MAG_W-1:0]            overlap_mag
);
  import qfom_pkg::*;

  qfom_cfg_t   cfg;
  qfom_entry_t push_entry;
  qfom_entry_t pop_entry;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  // Configuration registers, reset to k = 1, Q = 0, c = 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.qubit_count <= K_W'(1);
      cfg.quad_form   <= '0;
      cfg.linear_mask <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_QUBIT_COUNT: cfg.qubit_count <= cfg_data[K_W-1:0];
        REG_QUAD_FORM:   cfg.quad_form   <= cfg_data[QF_W-1:0];
        REG_LINEAR_MASK: cfg.linear_mask <= cfg_data[MAX_QUBITS-1:0];
        default:         ;
      endcase
    end
  end

  // Phase and accumulate, one sample per cycle unless the queue is full.
  qfom_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  // Decouples the streaming front from the multi-cycle magnitude path.
  qfom_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (push_entry),
    .pop      (q_pop),
    .rd_entry (pop_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Square, scale, root, output register.
  qfom_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_entry     (pop_entry),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .overlap_mag (overlap_mag)
  );

endmodule

// File: sim/overlap_mag_checker.sv
// Transaction checker for the quadratic-form overlap magnitude unit: tracks register
// writes and samples, predicts each overlap_mag and compares it with the output.
// Uses qfom_pkg for widths and register indexes.
module overlap_mag_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [qfom_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qfom_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [qfom_pkg::SAMPLE_W-1:0] sample_re,
  input  logic signed [qfom_pkg::SAMPLE_W-1:0] sample_im,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [qfom_pkg::MAG_W-1:0]           overlap_mag,
  output int                                   fail_count,
  output int                                   pending,
  output int                                   results_seen
);
  import qfom_pkg::*;

  logic [K_W-1:0]        qubits_reg;
  logic [QF_W-1:0]       form_reg;
  logic [MAX_QUBITS-1:0] mask_reg;
  longint                sum_re;
  longint                sum_im;
  int                    pos_in_block;
  logic [MAG_W-1:0]      mag_queue[$];

  function automatic int span_bits(logic [K_W-1:0] k);
    if (k == 0) return 1;
    if (k > MAX_QUBITS) return MAX_QUBITS;
    return int'(k);
  endfunction

  // bit 1: sign flip from x'Qx, bit 0: factor i from parity(c & x)
  function automatic logic [1:0] sample_phase(logic [MAX_QUBITS-1:0] x, int k,
                                              logic [QF_W-1:0] q,
                                              logic [MAX_QUBITS-1:0] c);
    logic quad;
    logic lin;
    int   pos;
    quad = 1'b0;
    lin  = 1'b0;
    pos  = 0;
    for (int i = 0; i < k; i++) begin
      lin ^= x[i] & c[i];
      for (int j = i; j < k; j++) begin
        quad ^= x[i] & x[j] & q[pos];
        pos++;
      end
    end
    return {quad, lin};
  endfunction

  // floor(sqrt((re^2 + im^2) >> k)), saturated to the output width
  function automatic logic [MAG_W-1:0] scaled_mag(longint re, longint im, int k);
    longint unsigned power;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    power = re * re + im * im;
    rem   = power >> k;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    if (root > MAG_MAX) return MAG_MAX;
    return root[MAG_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    int                    k;
    int                    last;
    logic [MAX_QUBITS-1:0] x;
    logic [1:0]            ph;
    longint                pre;
    longint                pim;
    longint                swap;
    logic [MAG_W-1:0]      want;
    if (rst) begin
      qubits_reg   = 4'd1;
      form_reg     = '0;
      mask_reg     = '0;
      sum_re       = 0;
      sum_im       = 0;
      pos_in_block = 0;
      mag_queue.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // sample first: a write at the same edge only affects later samples
      if (in_valid && !in_stall) begin
        k    = span_bits(qubits_reg);
        last = (1 << k) - 1;
        x    = MAX_QUBITS'(pos_in_block & last);
        ph   = sample_phase(x, k, form_reg, mask_reg);
        pre  = sample_re;
        pim  = sample_im;
        if (ph[0]) begin
          swap = pre;
          pre  = -pim;
          pim  = swap;
        end
        if (ph[1]) begin
          pre = -pre;
          pim = -pim;
        end
        sum_re += pre;
        sum_im += pim;
        if (pos_in_block >= last) begin
          want         = scaled_mag(sum_re, sum_im, k);
          mag_queue    = {mag_queue, want};
          sum_re       = 0;
          sum_im       = 0;
          pos_in_block = 0;
        end else begin
          pos_in_block = (pos_in_block + 1) & 1023;
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_QUBIT_COUNT: qubits_reg = cfg_data[K_W-1:0];
          REG_QUAD_FORM:   form_reg   = cfg_data[QF_W-1:0];
          REG_LINEAR_MASK: mask_reg   = cfg_data[MAX_QUBITS-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        results_seen++;
        if (mag_queue.size() == 0) begin
          fail_count++;
          $display("%0t: overlap_mag unexpected, expected none, got %0d", $time, overlap_mag);
        end else begin
          want = mag_queue.pop_front();
          if (overlap_mag !== want) begin
            fail_count++;
            $display("%0t: overlap_mag mismatch, expected %0d, got %0d",
                     $time, want, overlap_mag);
          end
        end
      end
    end
    pending = mag_queue.size();
  end

endmodule

// File: sim/quadratic_form_overlap_magnitude_unit_tb.sv
// Testbench top for the quadratic-form overlap magnitude unit: clock, reset,
// sample and register stimulus, receiver back-pressure, watchdog and verdict.
// Depends on qfom_pkg, the unit itself and overlap_mag_checker.
module quadratic_form_overlap_magnitude_unit_tb;
  import qfom_pkg::*;

  localparam int RANDOM_ITEMS   = 1580;
  localparam int DRAIN_CYCLES   = 64;    // extra wait after the last expected result
  localparam int HOLD_AFTER     = 12;    // results seen before the long output hold
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction

  // index 3 is decoded by nobody; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum {SMP_RANDOM, SMP_CONST, SMP_MIXED} sample_mode_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample_re = '0;
  logic signed [SAMPLE_W-1:0] sample_im = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [MAG_W-1:0]           overlap_mag;

  int fail_count;
  int pending;
  int results_seen;
  int samples_sent = 0;
  int settings     = 0;
  bit gaps_on      = 1'b1;

  always #5 clk = ~clk;

  quadratic_form_overlap_magnitude_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_re   (sample_re),
    .sample_im   (sample_im),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .overlap_mag (overlap_mag)
  );

  overlap_mag_checker mag_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_re    (sample_re),
    .sample_im    (sample_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .overlap_mag  (overlap_mag),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Field extremes, tiny signed values and full-range noise.
  function automatic logic [SAMPLE_W-1:0] mixed_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'($urandom_range(0, 31)) - 16'd16;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int eff_qubits(logic [K_W-1:0] k);
    if (k == 0) return 1;
    if (k > MAX_QUBITS) return MAX_QUBITS;
    return int'(k);
  endfunction

  // One sample transaction. Called and returning at a falling edge; valid is
  // left high so back-to-back samples never lower and raise it in one step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_re <= re;
    sample_im <= im;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic send_block(input int k, input sample_mode_t mode);
    logic [SAMPLE_W-1:0] cre;
    logic [SAMPLE_W-1:0] cim;
    cre = mixed_value();
    cim = mixed_value();
    for (int n = 0; n < (1 << k); n++) begin
      case (mode)
        SMP_CONST: send_sample(cre, cim);
        SMP_MIXED: send_sample(mixed_value(), mixed_value());
        default:   send_sample(16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  // Drop valid, wait for every expected result, then wait out DRAIN_CYCLES; a
  // partial block stays in the front accumulator and yields no result yet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_write high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [K_W-1:0] k, input logic [QF_W-1:0] q,
                               input logic [MAX_QUBITS-1:0] c, input bit spare);
    write_reg(REG_QUBIT_COUNT, CFG_DATA_W'(k));
    write_reg(REG_QUAD_FORM, q);
    write_reg(REG_LINEAR_MASK, CFG_DATA_W'(c));
    if (spare) write_reg(REG_SPARE, CFG_DATA_W'({$urandom(), $urandom()}));
    cfg_write <= 1'b0;
    settings++;
  endtask

  // Receiver: random stalls, ready stretches, and one long hold once traffic
  // is flowing so the block-sum queue backs up into in_stall.
  initial begin : receiver
    int left;
    bit stall_now;
    bit hold_done;
    left      = 0;
    stall_now = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall_now = 1'b1;
        left      = HOLD_CYCLES;
      end else if (left == 0) begin
        if (stall_now) begin
          stall_now = 1'b0;
          left      = ($urandom_range(0, 19) == 0) ? 100 : $urandom_range(1, 8);
        end else begin
          left      = gap_len();
          stall_now = (left != 0);
          if (left == 0) left = 1;
        end
      end
      out_stall <= stall_now;
      left--;
    end
  end

  // Watchdog: any cycle with a transaction on either channel or a register
  // write resets the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles, %0d result(s) outstanding",
                 $time, quiet, pending);
        $display("quadratic_form_overlap_magnitude_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [K_W-1:0]        k_raw;
    logic [QF_W-1:0]       form;
    logic [MAX_QUBITS-1:0] mask;
    int                    k;
    int                    blocks;
    int                    stop_at;
    int                    big_at;
    bit                    big_done;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---
    // reset values (k = 1, Q = 0, c = 0) with opposite-sign extremes
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h7fff, 16'h8000);

    // k = 0 reads as 1; full form and mask
    settle();
    load_settings(4'd0, {QF_W{1'b1}}, {MAX_QUBITS{1'b1}}, 1'b0);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h7fff);

    // k = 2 with a cross term and a mask bit
    settle();
    load_settings(4'd2, 55'h6, 10'h2, 1'b1);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hffff, 16'hffff);
    send_sample(16'h0001, 16'h0001);
    send_sample(16'h7fff, 16'h8000);

    // k = 3, mixed form
    settle();
    load_settings(4'd3, 55'h2b, 10'h5, 1'b0);
    send_block(3, SMP_MIXED);

    // k shrinks mid-block: index 5 is already past the end of a k = 2 block,
    // so the next sample finishes it at once with x = 5 & 3
    settle();
    load_settings(4'd3, {QF_W{1'b1}}, 10'h0, 1'b0);
    repeat (5) send_sample(mixed_value(), mixed_value());
    settle();
    write_reg(REG_QUBIT_COUNT, CFG_DATA_W'(2));
    cfg_write <= 1'b0;
    send_sample(16'h8000, 16'h8000);

    // k grows mid-block: the block started at k = 1 ends at index 3
    settle();
    write_reg(REG_QUBIT_COUNT, CFG_DATA_W'(1));
    cfg_write <= 1'b0;
    send_sample(mixed_value(), mixed_value());
    settle();
    write_reg(REG_QUBIT_COUNT, CFG_DATA_W'(2));
    cfg_write <= 1'b0;
    repeat (3) send_sample(mixed_value(), mixed_value());

    // Twenty k = 1 blocks in a row: the sender cannot finish before about
    // sixteen results are out, so the long output hold starts while samples
    // are still offered and the unit fills up and stalls its input.
    settle();
    load_settings(4'd1, 55'h1, 10'h1, 1'b0);
    repeat (20) send_block(1, SMP_RANDOM);

    // --- random ---
    // Mostly short blocks; one full-size block (k = 10, or 15 read as 10)
    // part-way through. Some phases end on a partial block so the next
    // setting lands mid-stream.
    stop_at  = samples_sent + RANDOM_ITEMS;
    big_at   = samples_sent + 500;
    big_done = 1'b0;
    while (samples_sent < stop_at) begin
      settle();
      if (!big_done && samples_sent >= big_at) begin
        k_raw    = $urandom_range(0, 1) ? 4'd15 : 4'd10;
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0:        k_raw = 4'd0;
          1, 2:     k_raw = 4'($urandom_range(6, 8));
          3, 4, 5:  k_raw = 4'($urandom_range(4, 5));
          default:  k_raw = 4'($urandom_range(1, 3));
        endcase
      end
      case ($urandom_range(0, 9))
        0, 1, 2: form = {QF_W{1'b1}};
        3, 4:    form = '0;
        default: form = QF_W'({$urandom(), $urandom()});
      endcase
      case ($urandom_range(0, 9))
        0, 1:    mask = {MAX_QUBITS{1'b1}};
        2, 3:    mask = '0;
        default: mask = MAX_QUBITS'($urandom);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      load_settings(k_raw, form, mask, $urandom_range(0, 19) == 0);

      k      = eff_qubits(k_raw);
      blocks = (k <= 3) ? $urandom_range(1, 8) : (k <= 5) ? $urandom_range(1, 3) : 1;
      repeat (blocks) send_block(k, sample_mode_t'($urandom_range(0, 2)));
      if (k <= 5 && $urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, (1 << k) - 1)) send_sample(16'($urandom), 16'($urandom));
    end

    settle();
    $display("run covered %0d samples over %0d register settings, %0d results checked",
             samples_sent, settings, results_seen);
    $display("including out-of-range qubit_count, mid-block k changes and a %0d-cycle hold",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("quadratic_form_overlap_magnitude_unit_tb passed");
    end else begin
      $display("quadratic_form_overlap_magnitude_unit_tb failed");
    end
    $finish;
  end

endmodule
